/* hdl/bilinear_texture_sampler_unit_macros.svh */
// ----------------------------------------------------------------------------
// Bilinear texture sampler assertion macros
// Shared concurrent assertion forms for the sampler checkers.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH

// clocked check, quiet while reset is held
`define BTS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define BTS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/bts_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared widths, codes and the queue entry type.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int DIM_W       = 9;
    localparam int TEX_MAX_DEF = 256;
    localparam int WFB_DEF     = 8;
    localparam int WFB_MAX     = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int BYTE_W      = 8;
    localparam int NUM_CH      = 3;
    localparam int TEXEL_W     = NUM_CH * BYTE_W;
    localparam int COORD_W     = 16;
    localparam int OUT_W       = 16;
    localparam int TAP_N       = 4;
    localparam int K_W         = $clog2(TAP_N);
    localparam int IN_DATA_W   = 5 * BYTE_W + 2 * COORD_W;
    localparam int OUT_DATA_W  = NUM_CH * OUT_W;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 32;
    localparam int CFG_IDX_BIT = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_action              action;
        logic [DIM_W-1:0]     col0;
        logic [DIM_W-1:0]     col1;
        logic [DIM_W-1:0]     row0;
        logic [DIM_W-1:0]     row1;
        logic [WFB_MAX-1:0]   al;
        logic [WFB_MAX-1:0]   be;
        logic [TEXEL_W-1:0]   texel;
    } t_cmd;

endpackage

/* hdl/bts_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO between the classifying front end and the memory back end.
// ----------------------------------------------------------------------------
module bts_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bts_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output bts_pkg::t_cmd  o_cmd,
    output logic           o_empty,
    output logic           o_full
);
    import bts_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hdl/bts_front.sv */
// ----------------------------------------------------------------------------
// Sampler front end
// Accepts items, drops out-of-store writes, scales sample coordinates into
// texel indices and weights, and queues one command per kept item.
// ----------------------------------------------------------------------------
module bts_front #(
    parameter int MAX_TEX_WIDTH    = bts_pkg::TEX_MAX_DEF,
    parameter int MAX_TEX_HEIGHT   = bts_pkg::TEX_MAX_DEF,
    parameter int WEIGHT_FRAC_BITS = bts_pkg::WFB_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [bts_pkg::DIM_W-1:0]    i_tex_width,
    input  logic [bts_pkg::DIM_W-1:0]    i_tex_height,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  bts_pkg::t_action             i_action,
    input  logic [bts_pkg::BYTE_W-1:0]   i_texel_col,
    input  logic [bts_pkg::BYTE_W-1:0]   i_texel_row,
    input  logic [bts_pkg::TEXEL_W-1:0]  i_texel,
    input  logic [bts_pkg::COORD_W-1:0]  i_coord_u,
    input  logic [bts_pkg::COORD_W-1:0]  i_coord_v,
    output logic                         o_push,
    output bts_pkg::t_cmd                o_cmd,
    input  logic                         i_full
);
    import bts_pkg::*;

    localparam int SC_W = COORD_W + DIM_W;

    logic                r_valid;
    t_action             r_action;
    logic [BYTE_W-1:0]   r_col;
    logic [BYTE_W-1:0]   r_row;
    logic [TEXEL_W-1:0]  r_texel;
    logic [COORD_W-1:0]  r_u;
    logic [COORD_W-1:0]  r_v;

    logic [DIM_W-1:0]    w_dim;
    logic [DIM_W-1:0]    h_dim;
    logic [SC_W-1:0]     u_scaled;
    logic [SC_W-1:0]     v_scaled;
    logic [DIM_W-1:0]    x0;
    logic [DIM_W-1:0]    y0;
    logic [DIM_W-1:0]    x0_inc;
    logic [DIM_W-1:0]    y0_inc;
    logic                in_range;
    logic                keep;

    assign o_ready = !r_valid || !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_action <= i_action;
            r_col    <= i_texel_col;
            r_row    <= i_texel_row;
            r_texel  <= i_texel;
            r_u      <= i_coord_u;
            r_v      <= i_coord_v;
        end
    end

    always_comb begin
        if (i_tex_width == '0) begin
            w_dim = DIM_W'(1);
        end else if (32'(i_tex_width) > MAX_TEX_WIDTH) begin
            w_dim = DIM_W'(MAX_TEX_WIDTH);
        end else begin
            w_dim = i_tex_width;
        end
        if (i_tex_height == '0) begin
            h_dim = DIM_W'(1);
        end else if (32'(i_tex_height) > MAX_TEX_HEIGHT) begin
            h_dim = DIM_W'(MAX_TEX_HEIGHT);
        end else begin
            h_dim = i_tex_height;
        end
    end

    assign u_scaled = SC_W'(r_u) * SC_W'(w_dim);
    assign v_scaled = SC_W'(r_v) * SC_W'(h_dim);
    assign x0       = u_scaled[SC_W-1:COORD_W];
    assign y0       = v_scaled[SC_W-1:COORD_W];
    assign x0_inc   = x0 + 1'b1;
    assign y0_inc   = y0 + 1'b1;

    assign in_range = (32'(r_col) < MAX_TEX_WIDTH) && (32'(r_row) < MAX_TEX_HEIGHT);
    assign keep     = (r_action == ACT_SAMPLE) || in_range;
    assign o_push   = r_valid && !i_full && keep;

    always_comb begin
        o_cmd        = '0;
        o_cmd.action = r_action;
        o_cmd.texel  = r_texel;
        if (r_action == ACT_SAMPLE) begin
            o_cmd.col0 = x0;
            o_cmd.col1 = (x0_inc == w_dim) ? '0 : x0_inc;
            o_cmd.row0 = y0;
            o_cmd.row1 = (y0_inc == h_dim) ? '0 : y0_inc;
            o_cmd.al   = WFB_MAX'(u_scaled[COORD_W-1 -: WEIGHT_FRAC_BITS]);
            o_cmd.be   = WFB_MAX'(v_scaled[COORD_W-1 -: WEIGHT_FRAC_BITS]);
        end else begin
            o_cmd.col0 = DIM_W'(r_col);
            o_cmd.row0 = DIM_W'(r_row);
        end
    end

endmodule

/* hdl/bts_back.sv */
// ----------------------------------------------------------------------------
// Sampler back end
// Owns the single-port texel memory: stores writes, reads the four
// neighbours of a sample, weights and accumulates them, holds the result.
// ----------------------------------------------------------------------------
module bts_back #(
    parameter int MAX_TEX_WIDTH    = bts_pkg::TEX_MAX_DEF,
    parameter int MAX_TEX_HEIGHT   = bts_pkg::TEX_MAX_DEF,
    parameter int WEIGHT_FRAC_BITS = bts_pkg::WFB_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bts_pkg::t_cmd                   i_cmd,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bts_pkg::OUT_DATA_W-1:0]  o_data
);
    import bts_pkg::*;

    localparam int DEPTH     = MAX_TEX_WIDTH * MAX_TEX_HEIGHT;
    localparam int AW        = $clog2(DEPTH);
    localparam int WFB       = WEIGHT_FRAC_BITS;
    localparam int WT_W      = 2 * WFB + 1;
    localparam int SUM_W     = 2 * WFB + BYTE_W;
    localparam int OUT_SHIFT = 2 * WFB - BYTE_W;
    localparam logic [WFB:0]     WEIGHT_ONE = {1'b1, {WFB{1'b0}}};
    localparam logic [K_W-1:0]   K_LAST     = K_W'(TAP_N - 1);

    logic [TEXEL_W-1:0]  r_mem [DEPTH];
    logic [TEXEL_W-1:0]  r_rd;
    logic [K_W-1:0]      r_k;
    logic                r_mac_valid;
    logic                r_mac_first;
    logic                r_mac_last;
    logic [WT_W-1:0]     r_mac_wt;
    logic [SUM_W-1:0]    r_acc [NUM_CH];
    logic [SUM_W-1:0]    n_acc [NUM_CH];
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out [NUM_CH];

    logic                stall;
    logic                go;
    logic                is_sample;
    logic                we;
    logic                re;
    logic [DIM_W-1:0]    sel_col;
    logic [DIM_W-1:0]    sel_row;
    logic [AW-1:0]       addr;
    logic [WFB-1:0]      al;
    logic [WFB-1:0]      be;
    logic [WFB:0]        wa;
    logic [WFB:0]        wb;
    logic [WT_W-1:0]     wt;
    logic                load_out;

    assign stall     = r_mac_valid && r_mac_last && r_out_valid && !i_ready;
    assign go        = !i_empty && !stall;
    assign is_sample = (i_cmd.action == ACT_SAMPLE);
    assign we        = go && !is_sample;
    assign re        = go && is_sample;
    assign o_pop     = we || (re && (r_k == K_LAST));

    assign sel_col = (is_sample && r_k[0]) ? i_cmd.col1 : i_cmd.col0;
    assign sel_row = (is_sample && r_k[1]) ? i_cmd.row1 : i_cmd.row0;
    assign addr    = AW'(AW'(sel_row) * AW'(MAX_TEX_WIDTH)) + AW'(sel_col);

    assign al = i_cmd.al[WFB-1:0];
    assign be = i_cmd.be[WFB-1:0];
    assign wa = r_k[0] ? {1'b0, al} : WEIGHT_ONE - {1'b0, al};
    assign wb = r_k[1] ? {1'b0, be} : WEIGHT_ONE - {1'b0, be};
    assign wt = WT_W'(wa) * WT_W'(wb);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[addr] <= i_cmd.texel;
        end else if (re) begin
            r_rd <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_mac_valid <= 1'b0;
        end else begin
            if (re) begin
                r_k <= r_k + 1'b1;
            end
            if (!stall) begin
                r_mac_valid <= re;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_mac_first <= (r_k == '0);
            r_mac_last  <= (r_k == K_LAST);
            r_mac_wt    <= wt;
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_acc[c] = (r_mac_first ? '0 : r_acc[c])
                     + SUM_W'(r_mac_wt) * SUM_W'(r_rd[c*BYTE_W +: BYTE_W]);
        end
    end

    assign load_out = r_mac_valid && r_mac_last && !stall;

    always_ff @(posedge i_clk) begin
        if (r_mac_valid && !stall) begin
            r_acc <= n_acc;
        end
        if (load_out) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_out[c] <= n_acc[c][OUT_SHIFT +: OUT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            o_data[c*OUT_W +: OUT_W] = r_out[c];
        end
    end

endmodule

/* hdl/bilinear_texture_sampler_unit.sv */
// ----------------------------------------------------------------------------
// Bilinear texture sampler, wrap addressing
// A write beat stores one BGR texel; a sample beat returns the bilinear blend
// of the four texels around a wrapped 0.16 coordinate, 8.8 fixed point per
// channel. Every texel lives in one single-port memory, so a sample holds that
// port for one read per neighbour and a write for a single access; writes go
// at one per cycle while the result output is not stalled. A sample's result
// passes the front-end register, the command queue, the read-data and weight
// registers and the accumulator into the output register. The front end keeps
// taking beats while a result waits, until the four-entry command queue fills.
// Texel memory is not cleared after reset and must be written before it is sampled.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit #(
    parameter int MAX_TEX_WIDTH    = bts_pkg::TEX_MAX_DEF,
    parameter int MAX_TEX_HEIGHT   = bts_pkg::TEX_MAX_DEF,
    parameter int WEIGHT_FRAC_BITS = bts_pkg::WFB_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // texel_col, texel_row, texel_blue, texel_green, texel_red, coord_u, coord_v
    input  logic [bts_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // action
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_blue, out_green, out_red
    output logic [bts_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bts_pkg::CFG_AW-1:0]      paddr,
    input  logic [bts_pkg::CFG_DW-1:0]      pwdata,
    output logic [bts_pkg::CFG_DW-1:0]      prdata,
    output logic                            pready
);
    import bts_pkg::*;

    logic [DIM_W-1:0]  r_tex_width;
    logic [DIM_W-1:0]  r_tex_height;
    t_reg_idx          reg_idx;
    t_cmd              push_cmd;
    t_cmd              head_cmd;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_IDX_BIT]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= DIM_RESET;
            r_tex_height <= DIM_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_WIDTH:  r_tex_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_tex_height <= pwdata[DIM_W-1:0];
                default:    r_tex_width  <= r_tex_width;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = CFG_DW'(r_tex_width);
            REG_HEIGHT: prdata = CFG_DW'(r_tex_height);
            default:    prdata = '0;
        endcase
    end

    bts_front #(
        .MAX_TEX_WIDTH    (MAX_TEX_WIDTH),
        .MAX_TEX_HEIGHT   (MAX_TEX_HEIGHT),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tex_width  (r_tex_width),
        .i_tex_height (r_tex_height),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_action     (t_action'(i_s_axis_tuser)),
        .i_texel_col  (i_s_axis_tdata[0 +: BYTE_W]),
        .i_texel_row  (i_s_axis_tdata[BYTE_W +: BYTE_W]),
        .i_texel      (i_s_axis_tdata[2*BYTE_W +: TEXEL_W]),
        .i_coord_u    (i_s_axis_tdata[5*BYTE_W +: COORD_W]),
        .i_coord_v    (i_s_axis_tdata[5*BYTE_W+COORD_W +: COORD_W]),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_full       (q_full)
    );

    bts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bts_back #(
        .MAX_TEX_WIDTH    (MAX_TEX_WIDTH),
        .MAX_TEX_HEIGHT   (MAX_TEX_HEIGHT),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

/* hdl/bts_checker.sv */
// ----------------------------------------------------------------------------
// Sampler port checker
// Watches the top-level ports for result holding, reset and register readback.
// ----------------------------------------------------------------------------
`include "bilinear_texture_sampler_unit_macros.svh"

module bts_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [bts_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bts_pkg::CFG_AW-1:0]      paddr,
    input  logic [bts_pkg::CFG_DW-1:0]      pwdata,
    input  logic [bts_pkg::CFG_DW-1:0]      prdata,
    input  logic                            pready
);
    import bts_pkg::*;

    `BTS_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "result beat changed while stalled")

    `BTS_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result beat shown right after reset")

    `BTS_ASSERT_CLK(a_cfg_readback, i_clk, i_rst_n, (psel && penable && pwrite && pready) |=> (!psel || pwrite || (paddr[CFG_IDX_BIT] != $past(paddr[CFG_IDX_BIT])) || (prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0]))), "register readback differs from last write")

endmodule

bind bilinear_texture_sampler_unit bts_checker u_bts_checker (.*);

/* verif/bilinear_texture_sampler_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler unit testbench
// Fills texels with write beats, then samples at wrapped 0.16 coordinates
// across several texture sizes. A local texel store and blend predict every
// filtered colour, which is checked field by field in arrival order. Both
// stream sides idle at random; one phase holds the output for a long stretch,
// one runs without gaps and one pauses until the results have all come back.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit_test;
    import bts_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PCT       = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STORE_COLS     = TEX_MAX_DEF;
    localparam int STORE_ROWS     = TEX_MAX_DEF;
    localparam int WEIGHT_ONE     = 1 << WFB_DEF;
    localparam int SUM_SHIFT      = 2 * WFB_DEF - BYTE_W;

    typedef struct packed {
        logic [COORD_W-1:0] coord_v;
        logic [COORD_W-1:0] coord_u;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic [BYTE_W-1:0]  row;
        logic [BYTE_W-1:0]  col;
    } texel_beat_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } colour_t;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = ACT_WRITE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_AW-1:0]     paddr    = '0;
    logic [CFG_DW-1:0]     pwdata   = '0;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    logic [TEXEL_W-1:0] texel_mem [STORE_COLS*STORE_ROWS];
    bit                 texel_known [STORE_COLS*STORE_ROWS];
    logic [DIM_W-1:0]   width_reg  = DIM_RESET;
    logic [DIM_W-1:0]   height_reg = DIM_RESET;
    colour_t            pending_colours [$];
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles   = 0;
    bit                 steady   = 1'b0;
    bit                 hold_req = 1'b0;
    int unsigned        hold_left = 0;

    bilinear_texture_sampler_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic int unsigned usable_dim(logic [DIM_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > TEX_MAX_DEF) return TEX_MAX_DEF;
        return raw;
    endfunction

    function automatic void split_axis(input logic [COORD_W-1:0] coord,
                                       input logic [DIM_W-1:0] raw,
                                       output int unsigned lo, output int unsigned hi,
                                       output int unsigned frac);
        int unsigned dim;
        int unsigned scaled;
        dim    = usable_dim(raw);
        scaled = coord * dim;
        lo     = scaled >> COORD_W;
        hi     = (lo + 1 == dim) ? 0 : lo + 1;
        frac   = (scaled & 32'hFFFF) >> (COORD_W - WFB_DEF);
    endfunction

    function automatic colour_t blend_texels(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        int unsigned x0, x1, y0, y1, al, be, acc;
        int unsigned wt [TAP_N];
        logic [TEXEL_W-1:0] tap [TAP_N];
        colour_t res;
        split_axis(u, width_reg, x0, x1, al);
        split_axis(v, height_reg, y0, y1, be);
        wt[0]  = (WEIGHT_ONE - al) * (WEIGHT_ONE - be);
        wt[1]  = al * (WEIGHT_ONE - be);
        wt[2]  = (WEIGHT_ONE - al) * be;
        wt[3]  = al * be;
        tap[0] = texel_mem[y0 * STORE_COLS + x0];
        tap[1] = texel_mem[y0 * STORE_COLS + x1];
        tap[2] = texel_mem[y1 * STORE_COLS + x0];
        tap[3] = texel_mem[y1 * STORE_COLS + x1];
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc = 0;
            for (int k = 0; k < TAP_N; k++) begin
                acc += wt[k] * tap[k][ch*BYTE_W +: BYTE_W];
            end
            res[ch*OUT_W +: OUT_W] = OUT_W'(acc >> SUM_SHIFT);
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [OUT_W-1:0] want,
                                   logic [OUT_W-1:0] got);
        $display("mismatch on %s: expected %0h, got %0h at %0t", field, want, got, $realtime);
        mismatch_count++;
    endtask

    task automatic send_beat(t_action act, texel_beat_t beat);
        @(negedge i_clk);
        while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tuser  <= act;
        do @(posedge i_clk); while (!s_tready);
        if (act == ACT_WRITE) begin
            texel_mem[beat.row * STORE_COLS + beat.col]   = {beat.red, beat.green, beat.blue};
            texel_known[beat.row * STORE_COLS + beat.col] = 1'b1;
        end else begin
            pending_colours.insert(pending_colours.size(),
                                   blend_texels(beat.coord_u, beat.coord_v));
        end
    endtask

    task automatic write_texel(int unsigned col, int unsigned row,
                               logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] g,
                               logic [BYTE_W-1:0] r);
        texel_beat_t beat;
        beat       = IN_DATA_W'({$urandom(), $urandom(), $urandom()});
        beat.col   = BYTE_W'(col);
        beat.row   = BYTE_W'(row);
        beat.blue  = b;
        beat.green = g;
        beat.red   = r;
        send_beat(ACT_WRITE, beat);
    endtask

    task automatic fill_texel(int unsigned col, int unsigned row);
        if (!texel_known[row * STORE_COLS + col])
            write_texel(col, row, BYTE_W'($urandom()), BYTE_W'($urandom()),
                        BYTE_W'($urandom()));
    endtask

    task automatic sample_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
        int unsigned x0, x1, y0, y1, al, be;
        texel_beat_t beat;
        split_axis(u, width_reg, x0, x1, al);
        split_axis(v, height_reg, y0, y1, be);
        fill_texel(x0, y0);
        fill_texel(x1, y0);
        fill_texel(x0, y1);
        fill_texel(x1, y1);
        beat         = IN_DATA_W'({$urandom(), $urandom(), $urandom()});
        beat.coord_u = u;
        beat.coord_v = v;
        send_beat(ACT_SAMPLE, beat);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_colours.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(t_reg_idx idx, logic [DIM_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(idx) << CFG_IDX_BIT;
        pwdata  <= CFG_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_WIDTH) width_reg = value;
        else height_reg = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        drain();
        set_register(REG_WIDTH, w);
        set_register(REG_HEIGHT, h);
    endtask

    task automatic random_item();
        logic [COORD_W-1:0] u, v;
        if ($urandom_range(99, 0) < 20) begin
            write_texel($urandom_range(STORE_COLS - 1, 0), $urandom_range(STORE_ROWS - 1, 0),
                        BYTE_W'($urandom()), BYTE_W'($urandom()), BYTE_W'($urandom()));
        end else begin
            u = COORD_W'($urandom());
            v = COORD_W'($urandom());
            case ($urandom_range(9, 0))
                0: u = '0;
                1: u = '1;
                2: v = '0;
                3: v = '1;
                default: ;
            endcase
            sample_at(u, v);
        end
    endtask

    task automatic test_corner_texels();
        write_texel(0, 0, 8'hFF, 8'hFF, 8'hFF);
        write_texel(STORE_COLS - 1, 0, 8'h00, 8'h00, 8'h00);
        write_texel(0, STORE_ROWS - 1, 8'hFF, 8'h00, 8'hFF);
        write_texel(STORE_COLS - 1, STORE_ROWS - 1, 8'h00, 8'hFF, 8'h00);
        sample_at(16'h0000, 16'h0000);
        sample_at(16'hFFFF, 16'hFFFF);
        sample_at(16'hFFFF, 16'h0000);
        sample_at(16'h0000, 16'hFFFF);
        sample_at(16'h00FF, 16'h0080);
    endtask

    task automatic test_dim_limits();
        set_dims(DIM_W'(0), DIM_W'(511));
        sample_at(16'h1234, 16'hFFFF);
        sample_at(16'hFFFF, 16'h0000);
        set_dims(DIM_W'(1), DIM_W'(1));
        sample_at(16'hFFFF, 16'hFFFF);
        sample_at(16'h8000, 16'h0001);
        set_dims(DIM_W'(256), DIM_W'(1));
        sample_at(16'h7FFF, 16'hFFFF);
        sample_at(16'hFFFF, 16'h5555);
    endtask

    task automatic test_random_traffic(int unsigned count);
        repeat (count) random_item();
    endtask

    task automatic test_output_hold();
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (40) sample_at(COORD_W'($urandom()), COORD_W'($urandom()));
        steady   = 1'b0;
    endtask

    task automatic test_full_rate();
        steady = 1'b1;
        repeat (80) random_item();
        steady = 1'b0;
    endtask

    task automatic test_result_pause();
        repeat (4) begin
            repeat (15) random_item();
            drain();
        end
    endtask

    // output side: long hold on request, otherwise random stalls unless steady
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        colour_t got;
        colour_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_colours.size() == 0) begin
                report_mismatch("unexpected result", '0, got.blue);
            end else begin
                want = pending_colours.pop_front();
                if (got.blue != want.blue) report_mismatch("blue", want.blue, got.blue);
                if (got.green != want.green) report_mismatch("green", want.green, got.green);
                if (got.red != want.red) report_mismatch("red", want.red, got.red);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_texels();
        test_dim_limits();
        set_dims(DIM_W'(5), DIM_W'(3));
        test_random_traffic(120);
        set_dims(DIM_W'(256), DIM_W'(256));
        test_random_traffic(25);
        set_dims(DIM_W'(1), DIM_W'(2));
        test_random_traffic(60);
        set_dims(DIM_W'(255), DIM_W'(17));
        test_random_traffic(30);
        set_dims(DIM_W'($urandom_range(256, 1)), DIM_W'($urandom_range(256, 1)));
        test_random_traffic(30);
        set_dims(DIM_W'(16), DIM_W'(16));
        test_output_hold();
        test_full_rate();
        test_result_pause();
        set_dims(DIM_W'(2), DIM_W'(256));
        test_random_traffic(30);

        drain();
        if (mismatch_count == 0 && pending_colours.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/bts_pkg.sv
hdl/bts_queue.sv
hdl/bts_front.sv
hdl/bts_back.sv
hdl/bilinear_texture_sampler_unit.sv
hdl/bts_checker.sv
verif/bilinear_texture_sampler_unit_test.sv
